// File: hw/rtl/blr_pkg.sv
package blr_pkg;

    // Coordinate and error term widths
    localparam int COORD_BITS = 10;
    localparam int ERR_BITS   = COORD_BITS + 3;

    typedef logic [COORD_BITS-1:0]      t_coord;
    typedef logic signed [ERR_BITS-1:0] t_err;

    // Operation codes carried by an input transaction
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // Octant class of the active line
    typedef enum logic [2:0] {
        CASE_VERTICAL     = 3'd0,
        CASE_SHALLOW_UP   = 3'd1,
        CASE_STEEP_UP     = 3'd2,
        CASE_SHALLOW_DOWN = 3'd3,
        CASE_STEEP_DOWN   = 3'd4
    } t_line_case;

    typedef struct packed {
        logic   operation;
        t_coord start_x;
        t_coord start_y;
        t_coord finish_x;
        t_coord finish_y;
    } t_item;

    typedef struct packed {
        t_coord pixel_x;
        t_coord pixel_y;
        logic   pixel_valid;
        logic   pixel_last;
    } t_pixel;

    typedef struct packed {
        t_coord     walk_x;
        t_coord     walk_y;
        t_coord     major_end;
        t_coord     delta_x_abs;
        t_coord     delta_y_abs;
        t_err       decision_error;
        t_line_case line_case;
        logic       line_active;
    } t_line_state;

endpackage

// File: hw/rtl/blr_item_if.sv
interface blr_item_if;
    import blr_pkg::*;

    logic   valid;
    logic   ready;
    logic   operation;
    t_coord start_x;
    t_coord start_y;
    t_coord finish_x;
    t_coord finish_y;

    modport source (
        output valid, operation, start_x, start_y, finish_x, finish_y,
        input  ready
    );
    modport sink (
        input  valid, operation, start_x, start_y, finish_x, finish_y,
        output ready
    );
endinterface

interface blr_pixel_if;
    import blr_pkg::*;

    logic   valid;
    logic   ready;
    t_coord pixel_x;
    t_coord pixel_y;
    logic   pixel_valid;
    logic   pixel_last;

    modport source (
        output valid, pixel_x, pixel_y, pixel_valid, pixel_last,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_valid, pixel_last,
        output ready
    );
endinterface

// File: hw/rtl/blr_step.sv
module blr_step (
    input  blr_pkg::t_line_state i_state,
    input  blr_pkg::t_item       i_item,
    output blr_pkg::t_line_state o_state,
    output blr_pkg::t_pixel      o_pixel
);
    import blr_pkg::*;

    logic        swap;
    t_coord      x0;
    t_coord      y0;
    t_coord      x1;
    t_coord      y1;
    t_coord      dx;
    t_coord      dy;
    logic        rising;
    t_err        dx2;
    t_err        dy2;
    logic        shallow;
    logic        falling;
    logic        err_pos;
    t_coord      y_step;
    t_coord      major;
    logic        last;
    t_line_state ns;

    // Order endpoints and measure the deltas for a load
    always_comb begin
        swap = !((i_item.start_x < i_item.finish_x) ||
                 ((i_item.start_x == i_item.finish_x) &&
                  (i_item.start_y <= i_item.finish_y)));
        x0 = swap ? i_item.finish_x : i_item.start_x;
        y0 = swap ? i_item.finish_y : i_item.start_y;
        x1 = swap ? i_item.start_x  : i_item.finish_x;
        y1 = swap ? i_item.start_y  : i_item.finish_y;
        rising = (y1 >= y0);
        dx = x1 - x0;
        dy = rising ? (y1 - y0) : (y0 - y1);
    end

    // Compute the next line state
    always_comb begin
        ns = i_state;
        // doubled deltas of the stored line, zero extended
        dx2 = t_err'({2'b00, i_state.delta_x_abs, 1'b0});
        dy2 = t_err'({2'b00, i_state.delta_y_abs, 1'b0});
        err_pos = !i_state.decision_error[ERR_BITS-1];
        falling = (i_state.line_case == CASE_SHALLOW_DOWN) ||
                  (i_state.line_case == CASE_STEEP_DOWN);
        y_step  = falling ? (i_state.walk_y - t_coord'(1)) : (i_state.walk_y + t_coord'(1));

        if (i_item.operation == OP_LOAD) begin
            ns.walk_x      = x0;
            ns.walk_y      = y0;
            ns.delta_x_abs = dx;
            ns.delta_y_abs = dy;
            ns.line_active = 1'b1;
            if (dx == '0) begin
                ns.line_case      = CASE_VERTICAL;
                ns.major_end      = y1;
                ns.decision_error = '0;
            end else if (dy <= dx) begin
                ns.line_case      = rising ? CASE_SHALLOW_UP : CASE_SHALLOW_DOWN;
                ns.major_end      = x1;
                ns.decision_error = t_err'({2'b00, dy, 1'b0}) - t_err'({3'b000, dx});
            end else begin
                ns.line_case      = rising ? CASE_STEEP_UP : CASE_STEEP_DOWN;
                ns.major_end      = y1;
                ns.decision_error = t_err'({2'b00, dx, 1'b0}) - t_err'({3'b000, dy});
            end
        end else if (i_state.line_active) begin
            case (i_state.line_case)
                CASE_SHALLOW_UP, CASE_SHALLOW_DOWN: begin
                    ns.walk_x = i_state.walk_x + t_coord'(1);
                    if (err_pos) begin
                        ns.walk_y         = y_step;
                        ns.decision_error = i_state.decision_error + dy2 - dx2;
                    end else begin
                        ns.decision_error = i_state.decision_error + dy2;
                    end
                end
                CASE_STEEP_UP, CASE_STEEP_DOWN: begin
                    ns.walk_y = y_step;
                    if (err_pos) begin
                        ns.walk_x         = i_state.walk_x + t_coord'(1);
                        ns.decision_error = i_state.decision_error + dx2 - dy2;
                    end else begin
                        ns.decision_error = i_state.decision_error + dx2;
                    end
                end
                default: begin
                    ns.walk_y = i_state.walk_y + t_coord'(1);
                end
            endcase
        end
    end

    // Detect the final pixel and form the result
    always_comb begin
        shallow = (ns.line_case == CASE_SHALLOW_UP) || (ns.line_case == CASE_SHALLOW_DOWN);
        major   = shallow ? ns.walk_x : ns.walk_y;
        last    = (major == ns.major_end);
        o_state = ns;
        if ((i_item.operation == OP_ADVANCE) && !i_state.line_active) begin
            o_pixel = '0;
        end else begin
            o_pixel.pixel_x     = ns.walk_x;
            o_pixel.pixel_y     = ns.walk_y;
            o_pixel.pixel_valid = 1'b1;
            o_pixel.pixel_last  = last;
            if (last) begin
                o_state.line_active = 1'b0;
            end
        end
    end

endmodule

// File: hw/rtl/bresenham_line_rasterizer.sv
// Bresenham line rasterizer. A load transaction latches two endpoints,
// classes the line into vertical, shallow or steep rising or falling, and
// returns the first pixel; each advance transaction returns the next pixel
// and flags the final one with pixel_last. An advance with no line in
// progress returns a result with pixel_valid low and all fields zero. A new
// transaction is taken every clock while the output is not stalled; each
// transaction passes through the input register, then the result register,
// and the line state advances with each step. Ready falls only when the
// result register is held by a stalled output.
module bresenham_line_rasterizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    blr_item_if.sink    i_item,
    blr_pixel_if.source o_pixel
);
    import blr_pkg::*;

    logic        r_in_valid;
    t_item       r_in;
    t_line_state r_state;
    logic        r_out_valid;
    t_pixel      r_out;
    t_line_state n_state;
    t_pixel      n_pixel;
    logic        step_fire;
    logic        in_fire;

    // Advance the item into the result register when it has room
    assign step_fire = r_in_valid && (!r_out_valid || o_pixel.ready);
    assign i_item.ready = !r_in_valid || step_fire;
    assign in_fire = i_item.valid && i_item.ready;

    // Capture the incoming transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (step_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in.operation <= i_item.operation;
            r_in.start_x   <= i_item.start_x;
            r_in.start_y   <= i_item.start_y;
            r_in.finish_x  <= i_item.finish_x;
            r_in.finish_y  <= i_item.finish_y;
        end
    end

    blr_step u_step (
        .i_state (r_state),
        .i_item  (r_in),
        .o_state (n_state),
        .o_pixel (n_pixel)
    );

    // Update the line state with each step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (step_fire) begin
            r_state <= n_state;
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_pixel.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire) begin
            r_out <= n_pixel;
        end
    end

    assign o_pixel.valid       = r_out_valid;
    assign o_pixel.pixel_x     = r_out.pixel_x;
    assign o_pixel.pixel_y     = r_out.pixel_y;
    assign o_pixel.pixel_valid = r_out.pixel_valid;
    assign o_pixel.pixel_last  = r_out.pixel_last;

    // The final pixel of a line ends the line
    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_fire && n_pixel.pixel_last) |=> !r_state.line_active)
        else $error("line still active after its final pixel");

    // A load always yields a pixel
    a_load_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_fire && (r_in.operation == OP_LOAD)) |=> (r_out_valid && r_out.pixel_valid))
        else $error("load step produced no pixel");

    // An empty result carries no last flag and no coordinates
    a_empty_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.pixel_valid) |->
            (!r_out.pixel_last && (r_out.pixel_x == '0) && (r_out.pixel_y == '0)))
        else $error("empty result carries pixel data");

    // A waiting input item is neither lost nor altered
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !step_fire) |=> (r_in_valid && $stable(r_in)))
        else $error("input register changed while waiting");

endmodule
